// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the space-to-depth index unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define S2D_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define S2D_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/s2d_pkg.sv -----
// Shared widths, register codes, tables and types of the space-to-depth index unit.
package s2d_pkg;

  // Field widths
  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int CHAN_W     = 11;
  localparam int BATCH_W    = 4;
  localparam int IDX_W      = 35;
  localparam int STRIDE_W   = 4;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 11;
  localparam int CHANNELS_W = 12;

  // Derived widths
  localparam int SQ_W     = 2 * STRIDE_W;           // stride squared
  localparam int WS_W     = WIDTH_W + STRIDE_W;     // width * stride
  localparam int HS_W     = HEIGHT_W + STRIDE_W;    // height * stride
  localparam int REM_W    = CHANNELS_W;             // remainder of chan / out_c
  localparam int LINA_W   = 16;                     // chan + channels*batch
  localparam int LINB_W   = LINA_W + HEIGHT_W;      // row + height*(...)
  localparam int REOB_W   = LINA_W + HS_W;          // hs * (c2 + out_c*batch)
  localparam int REOC_W   = REOB_W + 1;             // plus h2
  localparam int H2_W     = 15;
  localparam int W2_W     = 14;
  localparam int DIV_STEPS = CHANNELS_W;            // iterations for out_c
  localparam int CNT_W    = $clog2(DIV_STEPS + 1);

  // Reciprocal table for off / stride: q = (off * RECIP_TBL[s]) >> RECIP_SHIFT
  localparam int RECIP_SHIFT = CHAN_W + STRIDE_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int QM_W        = CHAN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_TBL [16] = '{
    16'd0,    16'd32768, 16'd16384, 16'd10923, 16'd8192, 16'd6554, 16'd5462, 16'd4682,
    16'd4096, 16'd3641,  16'd3277,  16'd2979,  16'd2731, 16'd2521, 16'd2341, 16'd2185
  };

  // APB register file
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int REG_LSB = 2;

  typedef enum logic [ADDR_W-REG_LSB-1:0] {
    REG_STRIDE    = 3'd0,
    REG_WIDTH     = 3'd1,
    REG_HEIGHT    = 3'd2,
    REG_CHANNELS  = 3'd3,
    REG_DIRECTION = 3'd4
  } s2d_reg_e;

  // Reset values
  localparam logic [STRIDE_W-1:0]   RST_STRIDE   = 4'd2;
  localparam logic [WIDTH_W-1:0]    RST_WIDTH    = 11'd1024;
  localparam logic [HEIGHT_W-1:0]   RST_HEIGHT   = 11'd1024;
  localparam logic [CHANNELS_W-1:0] RST_CHANNELS = 12'd2048;
  localparam logic [SQ_W-1:0]       RST_SQ       = 8'd4;
  localparam logic [CHANNELS_W-1:0] RST_OUT_C    = 12'd512;
  localparam logic [WS_W-1:0]       RST_WS       = 15'd2048;
  localparam logic [HS_W-1:0]       RST_HS       = 15'd2048;

  // Configuration and derived values seen by the datapath
  typedef struct packed {
    logic [STRIDE_W-1:0]   stride;
    logic [WIDTH_W-1:0]    width;
    logic [HEIGHT_W-1:0]   height;
    logic [CHANNELS_W-1:0] channels;
    logic                  direction;
    logic [CHANNELS_W-1:0] out_c;
    logic [WS_W-1:0]       ws;
    logic [HS_W-1:0]       hs;
    logic                  bad_setup;
    logic                  busy;
  } s2d_cfg_t;

  // One divider cell's word: partial remainder, shifting dividend/quotient, side data
  typedef struct packed {
    logic                  vld;
    logic                  bad;
    logic [REM_W-1:0]      rem;
    logic [CHAN_W-1:0]     dq;
    logic [CHANNELS_W-1:0] divisor;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;
    logic [CHAN_W-1:0]     chan;
    logic [BATCH_W-1:0]    bi;
  } s2d_cell_t;

endpackage

// ----- rtl/s2d_in_if.sv -----
// Input channel: one tensor coordinate per word.
interface s2d_in_if;
  logic                         valid;
  logic                         ready;
  logic [s2d_pkg::COL_W-1:0]    col;
  logic [s2d_pkg::ROW_W-1:0]    row;
  logic [s2d_pkg::CHAN_W-1:0]   chan;
  logic [s2d_pkg::BATCH_W-1:0]  batch_index;

  modport source (output valid, col, row, chan, batch_index, input ready);
  modport sink   (input valid, col, row, chan, batch_index, output ready);
endinterface

// ----- rtl/s2d_out_if.sv -----
// Output channel: read and write index pair per word.
interface s2d_out_if;
  logic                       valid;
  logic                       ready;
  logic [s2d_pkg::IDX_W-1:0]  read_index;
  logic [s2d_pkg::IDX_W-1:0]  write_index;
  logic                       coordinate_error;

  modport source (output valid, read_index, write_index, coordinate_error, input ready);
  modport sink   (input valid, read_index, write_index, coordinate_error, output ready);
endinterface

// ----- rtl/s2d_cfg.sv -----
// APB register file with the iterative out_c = channels / stride^2 divider.
`include "assert_macros.svh"

module s2d_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [s2d_pkg::ADDR_W-1:0]   paddr_i,
  input  logic [s2d_pkg::DATA_W-1:0]   pwdata_i,
  output logic [s2d_pkg::DATA_W-1:0]   prdata_o,
  output s2d_pkg::s2d_cfg_t            cfg_o
);

  logic [s2d_pkg::STRIDE_W-1:0]   stride_q, stride_d;
  logic [s2d_pkg::WIDTH_W-1:0]    width_q, width_d;
  logic [s2d_pkg::HEIGHT_W-1:0]   height_q, height_d;
  logic [s2d_pkg::CHANNELS_W-1:0] channels_q, channels_d;
  logic                           direction_q, direction_d;
  logic [s2d_pkg::SQ_W-1:0]       sq_q;
  logic [s2d_pkg::WS_W-1:0]       ws_q;
  logic [s2d_pkg::HS_W-1:0]       hs_q;
  logic                           busy_q, busy_d;
  logic [s2d_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [s2d_pkg::SQ_W-1:0]       rem_q, rem_d;
  logic [s2d_pkg::CHANNELS_W-1:0] dq_q, dq_d;
  logic [s2d_pkg::SQ_W:0]         trial;
  logic                           fits;
  logic                           wr_en;
  logic [s2d_pkg::ADDR_W-s2d_pkg::REG_LSB-1:0] reg_idx;
  logic [2*s2d_pkg::CHANNELS_W-1:0] oc_prod;

  assign wr_en   = psel_i && penable_i && pwrite_i;
  assign reg_idx = paddr_i[s2d_pkg::ADDR_W-1:s2d_pkg::REG_LSB];

  // Register writes
  always_comb begin
    stride_d    = stride_q;
    width_d     = width_q;
    height_d    = height_q;
    channels_d  = channels_q;
    direction_d = direction_q;
    if (wr_en) begin
      case (reg_idx)
        s2d_pkg::REG_STRIDE:    stride_d    = pwdata_i[s2d_pkg::STRIDE_W-1:0];
        s2d_pkg::REG_WIDTH:     width_d     = pwdata_i[s2d_pkg::WIDTH_W-1:0];
        s2d_pkg::REG_HEIGHT:    height_d    = pwdata_i[s2d_pkg::HEIGHT_W-1:0];
        s2d_pkg::REG_CHANNELS:  channels_d  = pwdata_i[s2d_pkg::CHANNELS_W-1:0];
        s2d_pkg::REG_DIRECTION: direction_d = pwdata_i[0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      s2d_pkg::REG_STRIDE:    prdata_o = s2d_pkg::DATA_W'(stride_q);
      s2d_pkg::REG_WIDTH:     prdata_o = s2d_pkg::DATA_W'(width_q);
      s2d_pkg::REG_HEIGHT:    prdata_o = s2d_pkg::DATA_W'(height_q);
      s2d_pkg::REG_CHANNELS:  prdata_o = s2d_pkg::DATA_W'(channels_q);
      s2d_pkg::REG_DIRECTION: prdata_o = s2d_pkg::DATA_W'(direction_q);
      default:                prdata_o = '0;
    endcase
  end

  // Restoring divider: load in step 0, one quotient bit per later step
  always_comb begin
    trial = {rem_q, dq_q[s2d_pkg::CHANNELS_W-1]};
    fits  = trial >= {1'b0, sq_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dq_d   = dq_q;
    if (wr_en) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '0) begin
        rem_d = '0;
        dq_d  = channels_q;
      end else begin
        rem_d = fits ? s2d_pkg::SQ_W'(trial - {1'b0, sq_q}) : trial[s2d_pkg::SQ_W-1:0];
        dq_d  = {dq_q[s2d_pkg::CHANNELS_W-2:0], fits};
      end
      if (cnt_q == s2d_pkg::CNT_W'(s2d_pkg::DIV_STEPS)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stride_q    <= s2d_pkg::RST_STRIDE;
      width_q     <= s2d_pkg::RST_WIDTH;
      height_q    <= s2d_pkg::RST_HEIGHT;
      channels_q  <= s2d_pkg::RST_CHANNELS;
      direction_q <= 1'b0;
      sq_q        <= s2d_pkg::RST_SQ;
      ws_q        <= s2d_pkg::RST_WS;
      hs_q        <= s2d_pkg::RST_HS;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      rem_q       <= '0;
      dq_q        <= s2d_pkg::RST_OUT_C;
    end else begin
      stride_q    <= stride_d;
      width_q     <= width_d;
      height_q    <= height_d;
      channels_q  <= channels_d;
      direction_q <= direction_d;
      sq_q        <= s2d_pkg::SQ_W'(stride_q) * s2d_pkg::SQ_W'(stride_q);
      ws_q        <= s2d_pkg::WS_W'(width_q) * s2d_pkg::WS_W'(stride_q);
      hs_q        <= s2d_pkg::HS_W'(height_q) * s2d_pkg::HS_W'(stride_q);
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      dq_q        <= dq_d;
    end
  end

  always_comb begin
    cfg_o.stride    = stride_q;
    cfg_o.width     = width_q;
    cfg_o.height    = height_q;
    cfg_o.channels  = channels_q;
    cfg_o.direction = direction_q;
    cfg_o.out_c     = dq_q;
    cfg_o.ws        = ws_q;
    cfg_o.hs        = hs_q;
    cfg_o.bad_setup = (stride_q == '0) || (dq_q == '0);
    cfg_o.busy      = busy_q;
  end

  // Quotient check: out_c * sq <= channels < (out_c + 1) * sq
  assign oc_prod = (2*s2d_pkg::CHANNELS_W)'(dq_q) * (2*s2d_pkg::CHANNELS_W)'(sq_q);

  `S2D_ASSERT_IMPL(a_cnt_bound, busy_q, cnt_q <= s2d_pkg::CNT_W'(s2d_pkg::DIV_STEPS), "divider count overran")
  `S2D_ASSERT_NEXT(a_write_busy, wr_en, busy_q, "register write did not start recompute")
  `S2D_ASSERT_IMPL(a_out_c_exact, !busy_q && (sq_q != '0), (oc_prod <= (2*s2d_pkg::CHANNELS_W)'(channels_q)) && ((2*s2d_pkg::CHANNELS_W)'(channels_q) - oc_prod < (2*s2d_pkg::CHANNELS_W)'(sq_q)), "out_c is not the floor quotient")

endmodule

// ----- rtl/s2d_div_cell.sv -----
// One restoring-division cell: a quotient bit of chan / out_c per cell, side data rides along.
module s2d_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  s2d_pkg::s2d_cell_t cell_i,
  output s2d_pkg::s2d_cell_t cell_o
);

  logic [s2d_pkg::REM_W:0] trial;
  logic                    fits;
  s2d_pkg::s2d_cell_t      step;
  s2d_pkg::s2d_cell_t      data_q;
  logic                    vld_q;

  // Shift in the next dividend bit, subtract divisor if it fits
  always_comb begin
    trial     = {cell_i.rem, cell_i.dq[s2d_pkg::CHAN_W-1]};
    fits      = trial >= {1'b0, cell_i.divisor};
    step      = cell_i;
    step.rem  = fits ? s2d_pkg::REM_W'(trial - {1'b0, cell_i.divisor})
                     : trial[s2d_pkg::REM_W-1:0];
    step.dq   = {cell_i.dq[s2d_pkg::CHAN_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= cell_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= step;
    end
  end

  always_comb begin
    cell_o     = data_q;
    cell_o.vld = vld_q;
  end

endmodule

// ----- rtl/reorg_space_to_depth_index_unit.sv -----
// Space-to-depth (reorg) index unit: coordinate in, read/write flat index pair out.
//
// Usage:
//   in_i carries one coordinate word (col, row, chan, batch_index) under a
//   valid/ready handshake; out_o returns one word per coordinate with
//   read_index, write_index and coordinate_error. An out-of-range coordinate
//   or a degenerate set-up (stride 0, channels below stride squared) gives
//   coordinate_error with both indices zero.
//   An accepted word runs through the eleven-cell chain that divides chan by
//   out_c one quotient bit per cell, then four multiply stages and the output
//   register; throughput is one word per cycle while out_o does not stall and
//   no out_c recompute runs. Registers sit behind an APB port (stride, width,
//   height, channels, direction at 0x0..0x10). After each write in_i.ready
//   stays low while out_c = channels / stride^2 is recomputed by a bit-serial
//   divider. Reset loads the default set-up, ready follows at once. When out_o
//   is stalled a skid word absorbs one result, then the whole pipeline holds
//   and in_i.ready drops until the output drains.
`include "assert_macros.svh"

module reorg_space_to_depth_index_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [s2d_pkg::ADDR_W-1:0]  paddr,
  input  logic [s2d_pkg::DATA_W-1:0]  pwdata,
  output logic [s2d_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  s2d_in_if.sink                      in_i,
  s2d_out_if.source                   out_o
);

  typedef struct packed {
    logic [s2d_pkg::IDX_W-1:0] read_index;
    logic [s2d_pkg::IDX_W-1:0] write_index;
    logic                      coordinate_error;
  } s2d_res_t;

  s2d_pkg::s2d_cfg_t  cfg;
  s2d_pkg::s2d_cell_t chain [s2d_pkg::CHAN_W+1];
  s2d_pkg::s2d_cell_t tail;
  logic               pipe_en;
  logic               accept;

  // Stage registers after the divider chain
  logic                                s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic                                s1_bad_q, s2_bad_q, s3_bad_q, s4_bad_q;
  logic [s2d_pkg::CHAN_W-1:0]          s1_off_q, s2_off_q;
  logic [s2d_pkg::QM_W-1:0]            s1_qm_q;
  logic [s2d_pkg::LINA_W-1:0]          s1_lina_q, s1_oba_q;
  logic [s2d_pkg::COL_W-1:0]           s1_col_q, s2_col_q;
  logic [s2d_pkg::ROW_W-1:0]           s1_row_q, s2_row_q;
  logic [s2d_pkg::CHAN_W-1:0]          s2_offd_q;
  logic [s2d_pkg::LINB_W-1:0]          s2_linb_q;
  logic [s2d_pkg::REOB_W-1:0]          s2_reob_q;
  logic [s2d_pkg::REOC_W-1:0]          s3_reoc_q;
  logic [s2d_pkg::W2_W-1:0]            s3_w2_q;
  logic [s2d_pkg::IDX_W-1:0]           s3_lin_q, s4_lin_q, s4_reo_q;

  // Stage-3 helpers
  logic [s2d_pkg::H2_W-1:0]            offd_s;
  logic [s2d_pkg::STRIDE_W-1:0]        offm;
  logic [s2d_pkg::H2_W-1:0]            h2;
  logic [s2d_pkg::W2_W-1:0]            w2;

  // Output register and skid word
  s2d_res_t res;
  s2d_res_t out_q, out_d, skid_q, skid_d;
  logic     out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;

  s2d_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  assign pready      = 1'b1;
  assign pipe_en     = !skid_vld_q;
  assign in_i.ready  = pipe_en && !cfg.busy;
  assign accept      = in_i.valid && in_i.ready;

  // Chain entry: range check and divider load
  always_comb begin
    chain[0]         = '0;
    chain[0].vld     = accept;
    chain[0].bad     = ({1'b0, in_i.col} >= cfg.width) || ({1'b0, in_i.row} >= cfg.height) ||
                       ({1'b0, in_i.chan} >= cfg.channels) || cfg.bad_setup;
    chain[0].rem     = '0;
    chain[0].dq      = in_i.chan;
    chain[0].divisor = cfg.out_c;
    chain[0].col     = in_i.col;
    chain[0].row     = in_i.row;
    chain[0].chan    = in_i.chan;
    chain[0].bi      = in_i.batch_index;
  end

  // Row of division cells: off = chan / out_c, c2 = chan % out_c
  for (genvar g = 0; g < s2d_pkg::CHAN_W; g++) begin : g_cell
    s2d_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (pipe_en),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  assign tail = chain[s2d_pkg::CHAN_W];

  // Stage 3 arithmetic: off%stride from off and off/stride, then h2 and w2
  always_comb begin
    offd_s = s2d_pkg::H2_W'(s2_offd_q) * s2d_pkg::H2_W'(cfg.stride);
    offm   = s2d_pkg::STRIDE_W'(s2_off_q - offd_s[s2d_pkg::CHAN_W-1:0]);
    h2     = s2d_pkg::H2_W'(s2_row_q) * s2d_pkg::H2_W'(cfg.stride) +
             s2d_pkg::H2_W'(s2_offd_q);
    w2     = s2d_pkg::W2_W'(s2_col_q) * s2d_pkg::W2_W'(cfg.stride) +
             s2d_pkg::W2_W'(offm);
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (pipe_en) begin
      s1_vld_q <= tail.vld;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // Stage payloads: each stage holds its own multiplies
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      // S1: off * reciprocal, chan + channels*batch, c2 + out_c*batch
      s1_bad_q  <= tail.bad;
      s1_off_q  <= tail.dq;
      s1_qm_q   <= s2d_pkg::QM_W'(tail.dq) * s2d_pkg::QM_W'(s2d_pkg::RECIP_TBL[cfg.stride]);
      s1_lina_q <= s2d_pkg::LINA_W'(tail.chan) +
                   s2d_pkg::LINA_W'(cfg.channels) * s2d_pkg::LINA_W'(tail.bi);
      s1_oba_q  <= s2d_pkg::LINA_W'(tail.rem) +
                   s2d_pkg::LINA_W'(cfg.out_c) * s2d_pkg::LINA_W'(tail.bi);
      s1_col_q  <= tail.col;
      s1_row_q  <= tail.row;
      // S2: off / stride, row + height*(...), hs*(...)
      s2_bad_q  <= s1_bad_q;
      s2_off_q  <= s1_off_q;
      s2_offd_q <= s1_qm_q[s2d_pkg::RECIP_SHIFT+s2d_pkg::CHAN_W-1:s2d_pkg::RECIP_SHIFT];
      s2_linb_q <= s2d_pkg::LINB_W'(s1_row_q) +
                   s2d_pkg::LINB_W'(cfg.height) * s2d_pkg::LINB_W'(s1_lina_q);
      s2_reob_q <= s2d_pkg::REOB_W'(cfg.hs) * s2d_pkg::REOB_W'(s1_oba_q);
      s2_col_q  <= s1_col_q;
      s2_row_q  <= s1_row_q;
      // S3: linear index done, h2 folded into reorg partial
      s3_bad_q  <= s2_bad_q;
      s3_lin_q  <= s2d_pkg::IDX_W'(s2_col_q) +
                   s2d_pkg::IDX_W'(cfg.width) * s2d_pkg::IDX_W'(s2_linb_q);
      s3_reoc_q <= s2d_pkg::REOC_W'(s2_reob_q) + s2d_pkg::REOC_W'(h2);
      s3_w2_q   <= w2;
      // S4: reorg index done
      s4_bad_q  <= s3_bad_q;
      s4_lin_q  <= s3_lin_q;
      s4_reo_q  <= s2d_pkg::IDX_W'(s3_w2_q) +
                   s2d_pkg::IDX_W'(cfg.ws) * s2d_pkg::IDX_W'(s3_reoc_q);
    end
  end

  // Direction select and error zeroing
  always_comb begin
    if (s4_bad_q) begin
      res.read_index       = '0;
      res.write_index      = '0;
      res.coordinate_error = 1'b1;
    end else if (cfg.direction) begin
      res.read_index       = s4_lin_q;
      res.write_index      = s4_reo_q;
      res.coordinate_error = 1'b0;
    end else begin
      res.read_index       = s4_reo_q;
      res.write_index      = s4_lin_q;
      res.coordinate_error = 1'b0;
    end
  end

  // Output register with one skid word
  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (!out_vld_q || out_o.ready) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d  = s4_vld_q;
        out_d      = res;
      end
    end else if (s4_vld_q && pipe_en) begin
      skid_vld_d = 1'b1;
      skid_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.read_index       = out_q.read_index;
  assign out_o.write_index      = out_q.write_index;
  assign out_o.coordinate_error = out_q.coordinate_error;

  `S2D_ASSERT_IMPL(a_skid_needs_out, skid_vld_q, out_vld_q, "skid word held while output empty")
  `S2D_ASSERT_IMPL(a_err_zero_idx, out_vld_q && out_q.coordinate_error, (out_q.read_index == '0) && (out_q.write_index == '0), "error word carries nonzero index")
  `S2D_ASSERT_IMPL(a_busy_blocks, cfg.busy, !in_i.ready, "input taken during out_c recompute")

endmodule
